>>> design/imrot_pkg.sv
// Shared types and constants for the image rotation block.
// Used by the controller, the datapath and the top level; depends on nothing.
package imrot_pkg;

  // Image store geometry
  localparam int unsigned MaxSide  = 64;
  localparam int unsigned SideW    = $clog2(MaxSide);
  localparam int unsigned AddrW    = 2 * SideW;
  localparam int unsigned StoreDep = MaxSide * MaxSide;
  localparam int unsigned DimW     = 7;

  // Number formats
  localparam int unsigned PixW     = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned CoefW    = FracBits + 3;

  // Stream and configuration port widths
  localparam int unsigned InDataW  = 48;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Request kinds carried in the input side-band
  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_READ = 1'b1
  } req_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_IN_SIDE    = 3'd0,
    REG_OUT_SIDE   = 3'd1,
    REG_COS_SCALED = 3'd2,
    REG_SIN_SCALED = 3'd3,
    REG_FILL_VALUE = 3'd4
  } cfg_reg_e;

  // Corner fetched from the store
  typedef enum logic [1:0] {
    CORNER_TL,
    CORNER_TR,
    CORNER_BL,
    CORNER_BR
  } corner_e;

  // Source of the difference register
  typedef enum logic [1:0] {
    DIFF_NONE,
    DIFF_RD_A,
    DIFF_RD_B,
    DIFF_B_A
  } diff_e;

  // Result of evaluating one axis
  typedef struct packed {
    logic             ok;
    logic [SideW-1:0] lo;
    logic [SideW-1:0] hi;
    logic [FracBits-1:0] w;
  } axis_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    take_req;
    logic    store_px;
    logic    load_pos;
    logic    load_axis;
    logic    rd_en;
    corner_e corner;
    logic    cap_a;
    logic    cap_b;
    diff_e   diff;
    logic    mul_en;
    logic    mul_vert;
    logic    acc_a;
    logic    acc_b;
    logic    emit_pix;
    logic    emit_fill;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic axis_ok;
    logic out_free;
  } sts_t;

endpackage

>>> design/imrot_ram.sv
// Generic single-port RAM with registered read data.
// Stand-alone; holds the image store.
module imrot_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write, or read into the output register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/imrot_ctrl.sv
// Sequencer for the image rotation block: accepts requests and steps the
// datapath through position, corner fetch and blend. Uses imrot_pkg.
module imrot_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_kind_i,
  output logic               in_ready_o,
  input  imrot_pkg::sts_t    sts_i,
  output imrot_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS,
    ST_AXIS,
    ST_RD_TL,
    ST_RD_TR,
    ST_RD_BL,
    ST_RD_BR,
    ST_MIX_T,
    ST_MUL_B,
    ST_MIX_B,
    ST_DIFF_V,
    ST_MUL_V,
    ST_EMIT,
    ST_FILL
  } state_e;

  state_e state_q, state_d;
  logic   take;

  assign in_ready_o = (state_q == ST_IDLE);
  assign take       = in_valid_i && in_ready_o;

  // Decode state into datapath commands and the next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          if (in_kind_i == imrot_pkg::REQ_READ) begin
            cmd_o.take_req = 1'b1;
            state_d        = ST_POS;
          end else begin
            cmd_o.store_px = 1'b1;
          end
        end
      end
      ST_POS: begin
        cmd_o.load_pos = 1'b1;
        state_d        = ST_AXIS;
      end
      ST_AXIS: begin
        cmd_o.load_axis = 1'b1;
        state_d         = sts_i.axis_ok ? ST_RD_TL : ST_FILL;
      end
      ST_RD_TL: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.corner = imrot_pkg::CORNER_TL;
        state_d      = ST_RD_TR;
      end
      ST_RD_TR: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.corner = imrot_pkg::CORNER_TR;
        cmd_o.cap_a  = 1'b1;
        state_d      = ST_RD_BL;
      end
      ST_RD_BL: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.corner = imrot_pkg::CORNER_BL;
        cmd_o.diff   = imrot_pkg::DIFF_RD_A;
        state_d      = ST_RD_BR;
      end
      ST_RD_BR: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.corner = imrot_pkg::CORNER_BR;
        cmd_o.cap_b  = 1'b1;
        cmd_o.mul_en = 1'b1;
        state_d      = ST_MIX_T;
      end
      ST_MIX_T: begin
        cmd_o.acc_a = 1'b1;
        cmd_o.diff  = imrot_pkg::DIFF_RD_B;
        state_d     = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_MIX_B;
      end
      ST_MIX_B: begin
        cmd_o.acc_b = 1'b1;
        state_d     = ST_DIFF_V;
      end
      ST_DIFF_V: begin
        cmd_o.diff = imrot_pkg::DIFF_B_A;
        state_d    = ST_MUL_V;
      end
      ST_MUL_V: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_vert = 1'b1;
        state_d        = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_pix = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_FILL: begin
        if (sts_i.out_free) begin
          cmd_o.emit_fill = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/imrot_dp.sv
// Datapath of the image rotation block: configuration registers, source
// position, axis checks, image store, shared blend multiplier and result
// register. Uses imrot_pkg and imrot_ram.
module imrot_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [imrot_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [imrot_pkg::CfgDataW-1:0]    cfg_data_i,
  // request payload
  input  logic [imrot_pkg::SideW-1:0]       in_row_i,
  input  logic [imrot_pkg::SideW-1:0]       in_col_i,
  input  logic [imrot_pkg::PixW-1:0]        in_pix_i,
  // result side
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [imrot_pkg::PixW-1:0]        out_pix_o,
  output logic                              out_filled_o,
  // controller link
  input  imrot_pkg::cmd_t                   cmd_i,
  output imrot_pkg::sts_t                   sts_o
);

  localparam int unsigned SideW = imrot_pkg::SideW;
  localparam int unsigned DimW  = imrot_pkg::DimW;
  localparam int unsigned PixW  = imrot_pkg::PixW;
  localparam int unsigned Frac  = imrot_pkg::FracBits;
  localparam int unsigned CoefW = imrot_pkg::CoefW;
  localparam logic [DimW-1:0] MaxDim = DimW'(imrot_pkg::MaxSide);

  // Configuration registers
  logic [DimW-1:0]         in_side_q, out_side_q;
  logic signed [CoefW-1:0] cos_q, sin_q;
  logic [PixW-1:0]         fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_side_q  <= MaxDim;
      out_side_q <= '0;
      cos_q      <= CoefW'(1 << Frac);
      sin_q      <= '0;
      fill_q     <= '0;
    end else if (cfg_we_i) begin
      case (imrot_pkg::cfg_reg_e'(cfg_index_i))
        imrot_pkg::REG_IN_SIDE:    in_side_q  <= cfg_data_i[DimW-1:0];
        imrot_pkg::REG_OUT_SIDE:   out_side_q <= cfg_data_i[DimW-1:0];
        imrot_pkg::REG_COS_SCALED: cos_q      <= cfg_data_i[CoefW-1:0];
        imrot_pkg::REG_SIN_SCALED: sin_q      <= cfg_data_i[CoefW-1:0];
        imrot_pkg::REG_FILL_VALUE: fill_q     <= cfg_data_i[PixW-1:0];
        default: ;
      endcase
    end
  end

  // Effective input and output sides
  logic [DimW-1:0] n_side, m_side;

  always_comb begin
    if (in_side_q == '0) begin
      n_side = DimW'(1);
    end else if (in_side_q > MaxDim) begin
      n_side = MaxDim;
    end else begin
      n_side = in_side_q;
    end
    if (out_side_q == '0) begin
      m_side = n_side;
    end else if (out_side_q > MaxDim) begin
      m_side = MaxDim;
    end else begin
      m_side = out_side_q;
    end
  end

  // Capture the output coordinate of a read
  logic [SideW-1:0] row_q, col_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_req) begin
      row_q <= in_row_i;
      col_q <= in_col_i;
    end
  end

  // Source position in units of 2^-(Frac+1)
  logic signed [8:0]  dr, dc;
  logic signed [27:0] p_cr, p_sc, p_sr, p_cc;
  logic signed [31:0] base, pv_d, ph_d, pv_q, ph_q;

  always_comb begin
    dr   = $signed({2'b0, row_q, 1'b0}) - $signed({2'b0, m_side}) + 9'sd1;
    dc   = $signed({2'b0, col_q, 1'b0}) - $signed({2'b0, m_side}) + 9'sd1;
    p_cr = cos_q * dr;
    p_sc = sin_q * dc;
    p_sr = sin_q * dr;
    p_cc = cos_q * dc;
    base = $signed({9'b0, n_side - DimW'(1), 16'b0});
    pv_d = $signed({{4{p_cr[27]}}, p_cr}) + $signed({{4{p_sc[27]}}, p_sc}) + base;
    ph_d = $signed({{4{p_cc[27]}}, p_cc}) - $signed({{4{p_sr[27]}}, p_sr}) + base;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pos) begin
      pv_q <= pv_d;
      ph_q <= ph_d;
    end
  end

  // Map one position onto two indices and a weight
  function automatic imrot_pkg::axis_t axis_eval(input logic signed [31:0] p,
                                                 input logic [DimW-1:0] n);
    logic [DimW-1:0]    nm1;
    logic signed [8:0]  k;
    logic signed [31:0] band_lo, band_hi;
    logic [14:0]        t;
    imrot_pkg::axis_t   res;
    nm1     = n - DimW'(1);
    k       = $signed({1'b0, n, 1'b0}) - 9'sd3;
    band_lo = $signed({{7{k[8]}}, k, 16'b0});
    band_hi = $signed({8'b0, nm1, 17'b0});
    t       = p[31:17];
    res     = '0;
    if (p[31]) begin
      res.ok = 1'b0;
    end else if (p >= band_lo && p <= band_hi) begin
      // clamp band next to the last pixel
      res.ok = 1'b1;
      res.lo = nm1[SideW-1:0];
      res.hi = nm1[SideW-1:0];
      res.w  = '0;
    end else if (t >= {8'b0, nm1}) begin
      res.ok = 1'b0;
    end else begin
      res.ok = 1'b1;
      res.lo = t[SideW-1:0];
      res.hi = t[SideW-1:0] + SideW'(1);
      res.w  = p[Frac:1];
    end
    return res;
  endfunction

  imrot_pkg::axis_t ax_v, ax_h;
  logic [SideW-1:0] top_q, bot_q, lft_q, rgt_q;
  logic [Frac-1:0]  wv_q, wh_q;

  assign ax_v = axis_eval(pv_q, n_side);
  assign ax_h = axis_eval(ph_q, n_side);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_axis) begin
      top_q <= ax_v.lo;
      bot_q <= ax_v.hi;
      wv_q  <= ax_v.w;
      lft_q <= ax_h.lo;
      rgt_q <= ax_h.hi;
      wh_q  <= ax_h.w;
    end
  end

  // Image store
  logic [imrot_pkg::AddrW-1:0] ram_addr;
  logic [PixW-1:0]             ram_rdata;

  always_comb begin
    if (cmd_i.store_px) begin
      ram_addr = {in_row_i, in_col_i};
    end else begin
      case (cmd_i.corner)
        imrot_pkg::CORNER_TL: ram_addr = {top_q, lft_q};
        imrot_pkg::CORNER_TR: ram_addr = {top_q, rgt_q};
        imrot_pkg::CORNER_BL: ram_addr = {bot_q, lft_q};
        imrot_pkg::CORNER_BR: ram_addr = {bot_q, rgt_q};
        default:              ram_addr = {top_q, lft_q};
      endcase
    end
  end

  imrot_ram #(
    .Width (PixW),
    .Depth (imrot_pkg::StoreDep)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (cmd_i.store_px | cmd_i.rd_en),
    .we_i    (cmd_i.store_px),
    .addr_i  (ram_addr),
    .wdata_i (in_pix_i),
    .rdata_o (ram_rdata)
  );

  // Blend: a + floor(w * d / 2^Frac), one shared multiplier
  logic [PixW-1:0]      a_q, b_q;
  logic signed [PixW:0] d_q;
  logic signed [49:0]   prod_q;
  logic [Frac-1:0]      w_sel;
  logic [PixW-1:0]      blend_add;

  assign w_sel     = cmd_i.mul_vert ? wv_q : wh_q;
  assign blend_add = prod_q[PixW+Frac-1:Frac];

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_a) begin
      a_q <= ram_rdata;
    end else if (cmd_i.acc_a) begin
      a_q <= a_q + blend_add;
    end
    if (cmd_i.cap_b) begin
      b_q <= ram_rdata;
    end else if (cmd_i.acc_b) begin
      b_q <= b_q + blend_add;
    end
    case (cmd_i.diff)
      imrot_pkg::DIFF_RD_A:
        d_q <= $signed({ram_rdata[PixW-1], ram_rdata}) - $signed({a_q[PixW-1], a_q});
      imrot_pkg::DIFF_RD_B:
        d_q <= $signed({ram_rdata[PixW-1], ram_rdata}) - $signed({b_q[PixW-1], b_q});
      imrot_pkg::DIFF_B_A:
        d_q <= $signed({b_q[PixW-1], b_q}) - $signed({a_q[PixW-1], a_q});
      default: ;
    endcase
    if (cmd_i.mul_en) begin
      prod_q <= $signed({1'b0, w_sel}) * d_q;
    end
  end

  // Result register
  logic            out_valid_q;
  logic [PixW-1:0] out_pix_q;
  logic            out_filled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_pix || cmd_i.emit_fill) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_pix) begin
      out_pix_q    <= a_q + blend_add;
      out_filled_q <= 1'b0;
    end else if (cmd_i.emit_fill) begin
      out_pix_q    <= fill_q;
      out_filled_q <= 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_pix_o      = out_pix_q;
  assign out_filled_o   = out_filled_q;
  assign sts_o.axis_ok  = ax_v.ok & ax_h.ok;
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

endmodule

>>> design/image_rotate_bilinear.sv
// Top level of the rotating and resizing image store with bilinear blend.
// Joins imrot_ctrl, imrot_dp and the stream ports; uses imrot_pkg.
//
//   channel    direction  handshake                    payload
//   s_axis     in         s_axis_tvalid/s_axis_tready  row, col, pixel_in; tuser req_type
//   m_axis     out        m_axis_tvalid/m_axis_tready  pixel_out; tuser filled
//   cfg        in         cfg_valid_i/cfg_ready_o      register index, write data
//
// A load request is written into the single-port store on the cycle it is accepted.
// A read request occupies the block through position, axis check, four corner reads
// through the single store port and three blends sharing one multiplier, or emits
// the fill value if the source falls outside. Reset clears control state and sets
// the configuration registers to defaults; the store needs no clearing. A stalled
// result sits in the output register and further loads are still taken meanwhile.
module image_rotate_bilinear (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [imrot_pkg::InDataW-1:0]       s_axis_tdata,  // row[5:0], col[11:6], pixel_in[43:12]
  input  logic [0:0]                          s_axis_tuser,  // req_type[0]
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [imrot_pkg::PixW-1:0]          m_axis_tdata,  // pixel_out[31:0]
  output logic [0:0]                          m_axis_tuser,  // filled[0]
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [imrot_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [imrot_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam int unsigned SideW = imrot_pkg::SideW;
  localparam int unsigned PixW  = imrot_pkg::PixW;

  imrot_pkg::cmd_t cmd;
  imrot_pkg::sts_t sts;

  // Configuration is always taken
  assign cfg_ready_o = 1'b1;

  imrot_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  imrot_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i & cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_row_i     (s_axis_tdata[SideW-1:0]),
    .in_col_i     (s_axis_tdata[2*SideW-1:SideW]),
    .in_pix_i     (s_axis_tdata[2*SideW+PixW-1:2*SideW]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_pix_o    (m_axis_tdata),
    .out_filled_o (m_axis_tuser[0]),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule
